// ----- hw/rtl/bldc_six_step_commutator_defines.svh -----
// ============================================================================
// bldc six-step commutator assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ============================================================================
`ifndef BLDC_SIX_STEP_COMMUTATOR_DEFINES_SVH
`define BLDC_SIX_STEP_COMMUTATOR_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define BSSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BSSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/bssc_pkg.sv -----
// ============================================================================
// bssc_pkg
// tables, register indexes and reset codes of the six-step commutator
// ============================================================================
package bssc_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_ROTOR_OFFSET = 2'd0,
        CFG_PHASE_LEAD   = 2'd1,
        CFG_DUTY         = 2'd2,
        CFG_PWM_PERIOD   = 2'd3
    } t_cfg_idx;

    localparam int unsigned CFG_IDX_W = 2;

    typedef logic [2:0] t_rotor_tab [8];
    typedef logic [5:0] t_pattern_tab [8];

    // hall code to rotor state, codes 0 and 7 give the invalid state
    localparam t_rotor_tab ROTOR_TAB = '{
        3'd7, 3'd5, 3'd3, 3'd4, 3'd1, 3'd0, 3'd2, 3'd7
    };

    // drive pattern: bit 2i = phase i+1 low switch, bit 2i+1 = high switch
    localparam t_pattern_tab PATTERN_TAB = '{
        6'h12, 6'h18, 6'h09, 6'h21, 6'h24, 6'h06, 6'h00, 6'h00
    };

    localparam logic [2:0] HALL_ALL_LOW  = 3'd0;
    localparam logic [2:0] HALL_ALL_HIGH = 3'd7;

    localparam logic [2:0] OFFSET_RESET = 3'd0;
    localparam logic [2:0] LEAD_RESET   = 3'b110;   // -2

    // sector count of the electrical revolution, and its double
    localparam logic [5:0] SECTORS     = 6'd6;
    localparam logic [5:0] SECTORS_X2  = 6'd12;

endpackage

// ----- hw/rtl/bssc_hall_if.sv -----
// ============================================================================
// bssc_hall_if
// valid/ready channel carrying one sample of the three hall sensor bits
// ============================================================================
interface bssc_hall_if;

    logic       valid;
    logic       ready;
    logic [2:0] hall_bits;

    modport source (output valid, output hall_bits, input ready);
    modport sink   (input valid, input hall_bits, output ready);

endinterface

// ----- hw/rtl/bssc_drive_if.sv -----
// ============================================================================
// bssc_drive_if
// valid/ready channel carrying one gate drive word
// ============================================================================
interface bssc_drive_if;

    logic       valid;
    logic       ready;
    logic [2:0] low_side_on;
    logic [2:0] high_side_n;
    logic [2:0] drive_state;
    logic       hall_invalid;

    modport source (
        output valid, output low_side_on, output high_side_n,
        output drive_state, output hall_invalid, input ready
    );
    modport sink (
        input valid, input low_side_on, input high_side_n,
        input drive_state, input hall_invalid, output ready
    );

endinterface

// ----- hw/rtl/bldc_six_step_commutator.sv -----
// ============================================================================
// bldc_six_step_commutator
// hall sensor driven six-step commutation with pwm on the low-side gates
// ============================================================================
// Takes one word of three hall bits per cycle while the output side does not
// stall, and returns one gate drive word for it. The accepting edge loads the
// input register; the table lookups, the sector arithmetic and the pattern
// decode then feed the output register, which drives o_drive. Sustained rate
// is one word per clock while the output does not stall. i_hall.ready follows
// o_drive.ready combinationally through the two stages, so a stalled output
// holds at most two words in flight. The pwm counter advances once per
// accepted word (not per clock). It wraps to zero after reaching pwm_period-1,
// and period zero acts as one. The low-side gates of a word are on only when
// the counter stood below duty as the word was taken. High-side gates are
// active low. Drive states 6 and 7 switch every gate off. They are reached
// only by the sector sums -2 and -1, whose negative remainders keep their low
// three bits. An invalid hall code enters the sum as rotor state 7. The user
// must write configuration through i_cfg_we/i_cfg_idx/i_cfg_data only while
// no word is in flight; the block does not enforce this. There is no reset
// sweep.
// ============================================================================
`include "bldc_six_step_commutator_defines.svh"

module bldc_six_step_commutator #(
    parameter int unsigned PWM_WIDTH = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [bssc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [PWM_WIDTH-1:0]                i_cfg_data,

    // hall word in, drive word out
    bssc_hall_if.sink                           i_hall,
    bssc_drive_if.source                        o_drive
);

    // reset of duty and period: 1023 clipped to the counter width
    localparam int unsigned PWM_TOP_INT = (PWM_WIDTH >= 10) ? 1023 : (2**PWM_WIDTH - 1);
    localparam logic [PWM_WIDTH-1:0] PWM_TOP = PWM_WIDTH'(PWM_TOP_INT);

    // configuration registers
    logic [2:0]           r_offset;
    logic [2:0]           r_lead;
    logic [PWM_WIDTH-1:0] r_duty;
    logic [PWM_WIDTH-1:0] r_period;

    // pwm counter
    logic [PWM_WIDTH-1:0] r_pwm_cnt;
    logic [PWM_WIDTH-1:0] n_pwm_cnt;
    logic [PWM_WIDTH-1:0] pwm_last;

    // input stage
    logic                 r_s1_vld;
    logic [2:0]           r_s1_hall;
    logic                 r_s1_pwm_on;

    // output stage
    logic                 r_out_vld;
    logic [2:0]           r_low_on;
    logic [2:0]           r_high_n;
    logic [2:0]           r_state;
    logic                 r_invalid;

    logic                 in_acc;
    logic                 s2_adv;

    // decode of the input stage
    logic [2:0]           rotor;
    logic [5:0]           sum;
    logic [5:0]           rem;
    logic [2:0]           n_state;
    logic [5:0]           pat;
    logic [2:0]           n_low_on;
    logic [2:0]           n_high_n;
    logic                 n_invalid;

    // ------------------------------------------------------------------------
    // handshake: output register frees when empty or taken, input stage frees
    // when empty or moving on
    // ------------------------------------------------------------------------
    assign s2_adv       = !r_out_vld || o_drive.ready;
    assign i_hall.ready = !r_s1_vld || s2_adv;
    assign in_acc       = i_hall.valid && i_hall.ready;

    // ------------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= bssc_pkg::OFFSET_RESET;
            r_lead   <= bssc_pkg::LEAD_RESET;
            r_duty   <= PWM_TOP;
            r_period <= PWM_TOP;
        end else if (i_cfg_we) begin
            unique case (bssc_pkg::t_cfg_idx'(i_cfg_idx))
                bssc_pkg::CFG_ROTOR_OFFSET: r_offset <= i_cfg_data[2:0];
                bssc_pkg::CFG_PHASE_LEAD:   r_lead   <= i_cfg_data[2:0];
                bssc_pkg::CFG_DUTY:         r_duty   <= i_cfg_data;
                bssc_pkg::CFG_PWM_PERIOD:   r_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // pwm counter, one step per accepted word
    // ------------------------------------------------------------------------
    // period zero behaves as period one
    assign pwm_last  = (r_period == '0) ? '0 : r_period - PWM_WIDTH'(1);
    assign n_pwm_cnt = (r_pwm_cnt >= pwm_last) ? '0 : r_pwm_cnt + PWM_WIDTH'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_cnt <= '0;
        end else if (in_acc) begin
            r_pwm_cnt <= n_pwm_cnt;
        end
    end

    // ------------------------------------------------------------------------
    // input stage: hall bits and the pwm gate decision of this word
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_hall.ready) begin
            r_s1_vld <= i_hall.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_hall   <= i_hall.hall_bits;
            r_s1_pwm_on <= (r_pwm_cnt < r_duty);
        end
    end

    // ------------------------------------------------------------------------
    // sector arithmetic: rotor - offset + lead + 6 lies in -5..16, so the
    // truncating remainder by six is at most two subtractions; a negative
    // sum is its own remainder and keeps its low three bits
    // ------------------------------------------------------------------------
    assign rotor = bssc_pkg::ROTOR_TAB[r_s1_hall];

    always_comb begin
        sum = {3'b000, rotor} - {3'b000, r_offset}
            + {{3{r_lead[2]}}, r_lead} + bssc_pkg::SECTORS;
        priority if (sum[5]) begin
            rem = sum;
        end else if (sum >= bssc_pkg::SECTORS_X2) begin
            rem = sum - bssc_pkg::SECTORS_X2;
        end else if (sum >= bssc_pkg::SECTORS) begin
            rem = sum - bssc_pkg::SECTORS;
        end else begin
            rem = sum;
        end
    end

    assign n_state = rem[2:0];
    assign pat     = bssc_pkg::PATTERN_TAB[n_state];

    // even pattern bits are the low switches, odd bits the high switches
    assign n_low_on  = r_s1_pwm_on ? {pat[4], pat[2], pat[0]} : 3'b000;
    assign n_high_n  = ~{pat[5], pat[3], pat[1]};
    assign n_invalid = (r_s1_hall == bssc_pkg::HALL_ALL_LOW)
                    || (r_s1_hall == bssc_pkg::HALL_ALL_HIGH);

    // ------------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s2_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv && r_s1_vld) begin
            r_low_on  <= n_low_on;
            r_high_n  <= n_high_n;
            r_state   <= n_state;
            r_invalid <= n_invalid;
        end
    end

    assign o_drive.valid        = r_out_vld;
    assign o_drive.low_side_on  = r_low_on;
    assign o_drive.high_side_n  = r_high_n;
    assign o_drive.drive_state  = r_state;
    assign o_drive.hall_invalid = r_invalid;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    // never both switches of one phase on
    `BSSC_ASSERT_NOW(a_no_shoot_through, r_out_vld,
        (r_low_on & ~r_high_n) == 3'b000, "shoot through")
    // drive states six and seven switch every gate off
    `BSSC_ASSERT_NOW(a_off_states, r_out_vld && (r_state[2:1] == 2'b11),
        (r_low_on == 3'b000) && (r_high_n == 3'b111), "gates on in off state")
    // an accepted word is held in the input stage next cycle
    `BSSC_ASSERT_NEXT(a_accept_fills, in_acc, r_s1_vld, "accepted word lost")
    // the pwm counter only moves with an accepted word
    `BSSC_ASSERT_NEXT(a_cnt_hold, !in_acc, $stable(r_pwm_cnt),
        "pwm counter moved without word")

endmodule
